>>> rtl/core/slot_router_with_migration_assert.svh
// Assertion macros for the slot router checker.
`ifndef SLOT_ROUTER_WITH_MIGRATION_ASSERT_SVH
`define SLOT_ROUTER_WITH_MIGRATION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot router check failed");

// Next-cycle implication, disabled in reset.
`define SRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot router check failed");

`endif

>>> rtl/core/srm_pkg.sv
package srm_pkg;

  localparam int HASH_W     = 32;
  localparam int SRV_W      = 8;
  localparam int SLOT_W     = 10;
  localparam int ST_W       = 4;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    REQ_LOOKUP     = 2'd0,
    REQ_SET_STATUS = 2'd1,
    REQ_ASSIGN     = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_MISMATCH   = 2'd1,
    RES_UNASSIGNED = 2'd2,
    RES_BAD_RANGE  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_SLOT_COUNT = 2'd0,
    CFG_NOT_MOVING = 2'd1,
    CFG_MOVING     = 2'd2,
    CFG_MOVED      = 2'd3
  } cfg_idx_t;

endpackage

>>> rtl/core/slot_router_with_migration.sv
// Lookup / set-status: a 32-step serial modulo, memory read, check/write and
// result load precede out_valid. Range of N slots: one slot written per cycle;
// bad range or unknown type goes straight to the result load.
// in_ready returns with out_valid, so one request is in flight at a time, and a
// new one also waits for out_ready to free the result register.
// Reset: a clearing pass zeroes all tables, in_ready low; cfg anytime.
module slot_router_with_migration #(
  parameter int SLOTS       = 1024,
  parameter int SERVER_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [srm_pkg::HASH_W-1:0]      in_key_hash,
  input  logic [srm_pkg::ST_W-1:0]        in_status_value,
  input  logic [srm_pkg::ST_W-1:0]        in_expected_status,
  input  logic                            in_check_expected,
  input  logic [srm_pkg::SRV_W-1:0]       in_server_id,
  input  logic [srm_pkg::SLOT_W-1:0]      in_range_first,
  input  logic [srm_pkg::SLOT_W-1:0]      in_range_last,
  input  logic                            in_assign_kind,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srm_pkg::SLOT_W-1:0]      out_slot_number,
  output logic [srm_pkg::SRV_W-1:0]       out_chosen_server,
  output logic [srm_pkg::SRV_W-1:0]       out_old_owner,
  output logic [srm_pkg::SRV_W-1:0]       out_new_owner,
  output logic [srm_pkg::ST_W-1:0]        out_slot_state,
  output logic [srm_pkg::CNT_W-1:0]       out_slots_written,
  output logic [1:0]                      out_outcome,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import srm_pkg::*;

  localparam int SB   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW   = SERVER_BITS;
  localparam int DC_W = $clog2(HASH_W);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_LOOK  = 7'b0010000,
    ST_FILL  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DC_W-1:0]   cnt_r, cnt_nxt;
  logic [SB-1:0]     addr_r, addr_nxt;
  logic [SB-1:0]     last_r, last_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  req_t              req_r, req_nxt;
  logic [ST_W-1:0]   sval_r, sval_nxt;
  logic [ST_W-1:0]   exp_r, exp_nxt;
  logic              chk_r, chk_nxt;
  logic [SW-1:0]     srv_r, srv_nxt;
  logic              kind_r, kind_nxt;

  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [SRV_W-1:0]  res_chosen_r, res_chosen_nxt;
  logic [SRV_W-1:0]  res_own_r, res_own_nxt;
  logic [SRV_W-1:0]  res_tgt_r, res_tgt_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic [CNT_W-1:0]  res_written_r, res_written_nxt;
  outcome_t          res_outcome_r, res_outcome_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SRV_W-1:0]  out_chosen_r, out_chosen_nxt;
  logic [SRV_W-1:0]  out_own_r, out_own_nxt;
  logic [SRV_W-1:0]  out_tgt_r, out_tgt_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;
  logic [CNT_W-1:0]  out_written_r, out_written_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;

  logic [CNT_W-1:0]  slot_count_r;
  logic [ST_W-1:0]   code_not_moving_r, code_moving_r, code_moved_r;

  logic [SW-1:0]     own_mem [SLOTS];
  logic [SW-1:0]     tgt_mem [SLOTS];
  logic [ST_W-1:0]   st_mem  [SLOTS];
  logic [SW-1:0]     own_rd_r, tgt_rd_r;
  logic [ST_W-1:0]   st_rd_r;
  logic              own_we, tgt_we, st_we;
  logic [SW-1:0]     own_wd, tgt_wd;
  logic [ST_W-1:0]   st_wd;

  logic [CNT_W-1:0]  eff_count;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  rem_step;
  logic [31:0]       rem_ext, first_ext, last_ext, srv_ext, addr_ext, own_ext, tgt_ext;
  logic              bad_range;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r      <= CNT_W'(1024);
      code_not_moving_r <= ST_W'(1);
      code_moving_r     <= ST_W'(2);
      code_moved_r      <= ST_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SLOT_COUNT: slot_count_r      <= cfg_data[CNT_W-1:0];
        CFG_NOT_MOVING: code_not_moving_r <= cfg_data[ST_W-1:0];
        CFG_MOVING:     code_moving_r     <= cfg_data[ST_W-1:0];
        CFG_MOVED:      code_moved_r      <= cfg_data[ST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slot_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(slot_count_r) > SLOTS) begin
      eff_count = CNT_W'(SLOTS);
    end else begin
      eff_count = slot_count_r;
    end
  end

  // restoring modulo, one hash bit per step
  always_comb begin
    trial = {rem_r, hash_r[HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_step = CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_step = trial[CNT_W-1:0];
    end
  end

  assign rem_ext   = 32'(rem_step);
  assign first_ext = 32'(in_range_first);
  assign last_ext  = 32'(in_range_last);
  assign srv_ext   = 32'(in_server_id);
  assign addr_ext  = 32'(addr_r);
  assign own_ext   = 32'(own_rd_r);
  assign tgt_ext   = 32'(tgt_rd_r);
  assign bad_range = (in_range_first > in_range_last) || (last_ext >= SLOTS);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    addr_nxt        = addr_r;
    last_nxt        = last_r;
    hash_nxt        = hash_r;
    rem_nxt         = rem_r;
    div_nxt         = div_r;
    req_nxt         = req_r;
    sval_nxt        = sval_r;
    exp_nxt         = exp_r;
    chk_nxt         = chk_r;
    srv_nxt         = srv_r;
    kind_nxt        = kind_r;
    res_slot_nxt    = res_slot_r;
    res_chosen_nxt  = res_chosen_r;
    res_own_nxt     = res_own_r;
    res_tgt_nxt     = res_tgt_r;
    res_st_nxt      = res_st_r;
    res_written_nxt = res_written_r;
    res_outcome_nxt = res_outcome_r;
    out_valid_nxt   = out_valid_r;
    out_slot_nxt    = out_slot_r;
    out_chosen_nxt  = out_chosen_r;
    out_own_nxt     = out_own_r;
    out_tgt_nxt     = out_tgt_r;
    out_st_nxt      = out_st_r;
    out_written_nxt = out_written_r;
    out_outcome_nxt = out_outcome_r;
    own_we          = 1'b0;
    tgt_we          = 1'b0;
    st_we           = 1'b0;
    own_wd          = srv_r;
    tgt_wd          = srv_r;
    st_wd           = sval_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        own_we   = 1'b1;
        tgt_we   = 1'b1;
        st_we    = 1'b1;
        own_wd   = '0;
        tgt_wd   = '0;
        st_wd    = '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == SB'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          hash_nxt        = in_key_hash;
          rem_nxt         = '0;
          cnt_nxt         = '0;
          div_nxt         = eff_count;
          req_nxt         = req_t'(in_req_type);
          sval_nxt        = in_status_value;
          exp_nxt         = in_expected_status;
          chk_nxt         = in_check_expected;
          srv_nxt         = srv_ext[SW-1:0];
          kind_nxt        = in_assign_kind;
          addr_nxt        = first_ext[SB-1:0];
          last_nxt        = last_ext[SB-1:0];
          res_slot_nxt    = '0;
          res_chosen_nxt  = '0;
          res_own_nxt     = '0;
          res_tgt_nxt     = '0;
          res_st_nxt      = '0;
          res_written_nxt = '0;
          res_outcome_nxt = RES_OK;
          unique case (req_t'(in_req_type))
            REQ_LOOKUP, REQ_SET_STATUS: state_nxt = ST_DIV;
            REQ_ASSIGN: begin
              if (bad_range) begin
                res_outcome_nxt = RES_BAD_RANGE;
                state_nxt       = ST_DONE;
              end else begin
                res_written_nxt = CNT_W'(in_range_last) - CNT_W'(in_range_first)
                                  + CNT_W'(1);
                state_nxt       = ST_FILL;
              end
            end
            REQ_NONE: state_nxt = ST_DONE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_step;
        hash_nxt = hash_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DC_W'(HASH_W - 1)) begin
          addr_nxt  = rem_ext[SB-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        res_slot_nxt   = addr_ext[SLOT_W-1:0];
        res_own_nxt    = own_ext[SRV_W-1:0];
        res_tgt_nxt    = tgt_ext[SRV_W-1:0];
        res_st_nxt     = st_rd_r;
        res_chosen_nxt = (st_rd_r == code_moved_r) ? tgt_ext[SRV_W-1:0]
                                                   : own_ext[SRV_W-1:0];
        if (st_rd_r == '0) begin
          res_outcome_nxt = RES_UNASSIGNED;
        end else if (req_r == REQ_SET_STATUS) begin
          if (chk_r && (st_rd_r != exp_r)) begin
            res_outcome_nxt = RES_MISMATCH;
          end else begin
            st_we = 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_FILL: begin
        st_we = 1'b1;
        if (kind_r) begin
          tgt_we = 1'b1;
          st_wd  = code_moving_r;
        end else begin
          own_we = 1'b1;
          st_wd  = code_not_moving_r;
        end
        addr_nxt = addr_r + 1'b1;
        if (addr_r == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = res_slot_r;
          out_chosen_nxt  = res_chosen_r;
          out_own_nxt     = res_own_r;
          out_tgt_nxt     = res_tgt_r;
          out_st_nxt      = res_st_r;
          out_written_nxt = res_written_r;
          out_outcome_nxt = res_outcome_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r        <= last_nxt;
    hash_r        <= hash_nxt;
    rem_r         <= rem_nxt;
    div_r         <= div_nxt;
    req_r         <= req_nxt;
    sval_r        <= sval_nxt;
    exp_r         <= exp_nxt;
    chk_r         <= chk_nxt;
    srv_r         <= srv_nxt;
    kind_r        <= kind_nxt;
    res_slot_r    <= res_slot_nxt;
    res_chosen_r  <= res_chosen_nxt;
    res_own_r     <= res_own_nxt;
    res_tgt_r     <= res_tgt_nxt;
    res_st_r      <= res_st_nxt;
    res_written_r <= res_written_nxt;
    res_outcome_r <= res_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_own_r     <= out_own_nxt;
    out_tgt_r     <= out_tgt_nxt;
    out_st_r      <= out_st_nxt;
    out_written_r <= out_written_nxt;
    out_outcome_r <= out_outcome_nxt;
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[addr_r] <= own_wd;
    end
    own_rd_r <= own_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[addr_r] <= tgt_wd;
    end
    tgt_rd_r <= tgt_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[addr_r] <= st_wd;
    end
    st_rd_r <= st_mem[addr_r];
  end

  assign out_valid         = out_valid_r;
  assign out_slot_number   = out_slot_r;
  assign out_chosen_server = out_chosen_r;
  assign out_old_owner     = out_own_r;
  assign out_new_owner     = out_tgt_r;
  assign out_slot_state    = out_st_r;
  assign out_slots_written = out_written_r;
  assign out_outcome       = out_outcome_r;

endmodule

>>> rtl/core/srm_checker.sv
`include "slot_router_with_migration_assert.svh"

module srm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [srm_pkg::SLOT_W-1:0]      out_slot_number,
  input logic [srm_pkg::SRV_W-1:0]       out_chosen_server,
  input logic [srm_pkg::SRV_W-1:0]       out_old_owner,
  input logic [srm_pkg::SRV_W-1:0]       out_new_owner,
  input logic [srm_pkg::ST_W-1:0]        out_slot_state,
  input logic [srm_pkg::CNT_W-1:0]       out_slots_written,
  input logic [1:0]                      out_outcome
);
  import srm_pkg::*;

  // stalled result holds
  `SRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot_number) && $stable(out_chosen_server) && $stable(out_outcome) && $stable(out_slots_written))

  // route is always one of the two stored servers
  `SRM_ASSERT_NOW(a_chosen_src, out_valid, (out_chosen_server == out_old_owner) || (out_chosen_server == out_new_owner))

  // range fill reports no slot fields
  `SRM_ASSERT_NOW(a_fill_fields, out_valid && (out_slots_written != '0), (out_outcome == RES_OK) && (out_slot_number == '0) && (out_slot_state == '0))

  // status failures agree with the reported state
  `SRM_ASSERT_NOW(a_fail_state, out_valid && ((out_outcome == RES_UNASSIGNED) || (out_outcome == RES_MISMATCH)), (out_slots_written == '0) && ((out_outcome == RES_MISMATCH) ? (out_slot_state != '0) : (out_slot_state == '0)))

  // one request in flight
  `SRM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind slot_router_with_migration srm_checker u_srm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_slot_number   (out_slot_number),
  .out_chosen_server (out_chosen_server),
  .out_old_owner     (out_old_owner),
  .out_new_owner     (out_new_owner),
  .out_slot_state    (out_slot_state),
  .out_slots_written (out_slots_written),
  .out_outcome       (out_outcome)
);

>>> verif/testbench.sv
import srm_pkg::*;

typedef struct packed {
  req_t             req_type;
  logic [31:0]      key_hash;
  logic [3:0]       status_value;
  logic [3:0]       expected_status;
  logic             check_expected;
  logic [7:0]       server_id;
  logic [9:0]       range_first;
  logic [9:0]       range_last;
  logic             assign_kind;
} route_req_t;

typedef struct packed {
  logic [9:0]       slot_number;
  logic [7:0]       chosen_server;
  logic [7:0]       old_owner;
  logic [7:0]       new_owner;
  logic [3:0]       slot_state;
  logic [10:0]      slots_written;
  outcome_t         outcome;
} route_res_t;

class slot_route_tracker;
  bit [7:0]   owner_tbl [1024];
  bit [7:0]   target_tbl [1024];
  bit [3:0]   status_tbl [1024];
  bit [10:0]  slot_count = 11'd1024;
  bit [3:0]   code_not_moving = 4'd1;
  bit [3:0]   code_moving = 4'd2;
  bit [3:0]   code_moved = 4'd3;
  route_res_t routes_due[$];
  int         fail_count = 0;

  function int unsigned active_slots();
    if (slot_count == 0) return 1;
    if (slot_count > 1024) return 1024;
    return slot_count;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [10:0] data);
    case (idx)
      CFG_SLOT_COUNT: slot_count = data;
      CFG_NOT_MOVING: code_not_moving = data[3:0];
      CFG_MOVING:     code_moving = data[3:0];
      CFG_MOVED:      code_moved = data[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return routes_due.size();
  endfunction

  // Apply one accepted request to the table copy and queue its route result.
  function void take_request(route_req_t r);
    route_res_t  res;
    int unsigned slot;
    int unsigned i;
    res = '0;
    res.outcome = RES_OK;
    case (r.req_type)
      REQ_LOOKUP, REQ_SET_STATUS: begin
        slot = r.key_hash % active_slots();
        res.slot_number = slot;
        res.old_owner = owner_tbl[slot];
        res.new_owner = target_tbl[slot];
        res.slot_state = status_tbl[slot];
        res.chosen_server = (status_tbl[slot] == code_moved) ? target_tbl[slot]
                                                             : owner_tbl[slot];
        if (status_tbl[slot] == 0) begin
          res.outcome = RES_UNASSIGNED;
        end else if (r.req_type == REQ_SET_STATUS) begin
          if (r.check_expected && status_tbl[slot] != r.expected_status)
            res.outcome = RES_MISMATCH;
          else
            status_tbl[slot] = r.status_value;
        end
      end
      REQ_ASSIGN: begin
        if (r.range_first > r.range_last) begin
          res.outcome = RES_BAD_RANGE;
        end else begin
          for (i = r.range_first; i <= r.range_last; i++) begin
            if (r.assign_kind) begin
              target_tbl[i] = r.server_id;
              status_tbl[i] = code_moving;
            end else begin
              owner_tbl[i] = r.server_id;
              status_tbl[i] = code_not_moving;
            end
          end
          res.slots_written = r.range_last - r.range_first + 1;
        end
      end
      default: ;
    endcase
    routes_due.push_back(res);
  endfunction

  function void cmp(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endfunction

  function void match_route(route_res_t got);
    route_res_t want;
    if (routes_due.size() == 0) begin
      $error("route result with no request outstanding");
      fail_count++;
      return;
    end
    want = routes_due.pop_front();
    cmp("slot_number", want.slot_number, got.slot_number);
    cmp("chosen_server", want.chosen_server, got.chosen_server);
    cmp("old_owner", want.old_owner, got.old_owner);
    cmp("new_owner", want.new_owner, got.new_owner);
    cmp("slot_state", want.slot_state, got.slot_state);
    cmp("slots_written", want.slots_written, got.slots_written);
    cmp("outcome", want.outcome, got.outcome);
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_req_type;
  logic [HASH_W-1:0]     in_key_hash;
  logic [ST_W-1:0]       in_status_value;
  logic [ST_W-1:0]       in_expected_status;
  logic                  in_check_expected;
  logic [SRV_W-1:0]      in_server_id;
  logic [SLOT_W-1:0]     in_range_first;
  logic [SLOT_W-1:0]     in_range_last;
  logic                  in_assign_kind;
  logic                  out_valid;
  logic                  out_ready;
  logic [SLOT_W-1:0]     out_slot_number;
  logic [SRV_W-1:0]      out_chosen_server;
  logic [SRV_W-1:0]      out_old_owner;
  logic [SRV_W-1:0]      out_new_owner;
  logic [ST_W-1:0]       out_slot_state;
  logic [CNT_W-1:0]      out_slots_written;
  logic [1:0]            out_outcome;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_route_tracker sb;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int cycle_count = 0;

  slot_router_with_migration dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.match_route('{out_slot_number, out_chosen_server, out_old_owner, out_new_owner,
                       out_slot_state, out_slots_written, outcome_t'(out_outcome)});
  end

  function automatic route_req_t req_of(req_t k, logic [31:0] h, logic [3:0] sv,
                                        logic [3:0] es, logic ce, logic [7:0] srv,
                                        logic [9:0] f, logic [9:0] l, logic ak);
    return '{k, h, sv, es, ce, srv, f, l, ak};
  endfunction

  function automatic route_req_t rand_req(req_t k);
    return req_of(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
  endfunction

  // hash that lands on the given slot under the current slot count
  function automatic logic [31:0] hash_for(int unsigned slot);
    longint unsigned n;
    longint unsigned kmax;
    longint unsigned k;
    n = sb.active_slots();
    kmax = (64'hFFFF_FFFF - slot) / n;
    k = $urandom_range(32'(kmax));
    return 32'(k * n + slot);
  endfunction

  task automatic send_req(route_req_t r);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_req_type        <= r.req_type;
    in_key_hash        <= r.key_hash;
    in_status_value    <= r.status_value;
    in_expected_status <= r.expected_status;
    in_check_expected  <= r.check_expected;
    in_server_id       <= r.server_id;
    in_range_first     <= r.range_first;
    in_range_last      <= r.range_last;
    in_assign_kind     <= r.assign_kind;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.take_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [10:0] cnt, logic [3:0] not_moving, logic [3:0] moving,
                           logic [3:0] moved);
    write_reg(CFG_SLOT_COUNT, cnt);
    write_reg(CFG_NOT_MOVING, {7'd0, not_moving});
    write_reg(CFG_MOVING, {7'd0, moving});
    write_reg(CFG_MOVED, {7'd0, moved});
    cfg_valid <= 1'b0;
  endtask

  // owner fill, target fill, cut-over by compare-and-set, lookups, wrap-up
  task automatic run_migration();
    int unsigned n;
    int unsigned first;
    int unsigned last;
    int unsigned slot;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  want;
    n = sb.active_slots();
    first = $urandom_range(n - 1);
    last = first + $urandom_range(7);
    if (last > n - 1) last = n - 1;
    src = $urandom;
    dst = $urandom;
    slot = $urandom_range(last, first);
    send_req(req_of(REQ_ASSIGN, $urandom, $urandom, $urandom, $urandom, src,
                    first, last, 1'b0));
    send_req(req_of(REQ_ASSIGN, $urandom, $urandom, $urandom, $urandom, dst,
                    first, last, 1'b1));
    send_req(req_of(REQ_LOOKUP, hash_for(slot), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom));
    want = ($urandom_range(9) == 0) ? 4'($urandom) : sb.code_moving;
    send_req(req_of(REQ_SET_STATUS, hash_for(slot), sb.code_moved, want, 1'b1, $urandom,
                    $urandom, $urandom, $urandom));
    repeat ($urandom_range(3, 1))
      send_req(req_of(REQ_LOOKUP, hash_for($urandom_range(last, first)), $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom));
    if ($urandom_range(1))
      send_req(req_of(REQ_SET_STATUS, hash_for(slot), sb.code_not_moving, sb.code_moved,
                      1'b1, $urandom, $urandom, $urandom, $urandom));
    else
      send_req(req_of(REQ_ASSIGN, $urandom, $urandom, $urandom, $urandom, dst,
                      first, last, 1'b0));
  endtask

  task automatic send_noise();
    route_req_t  r;
    int unsigned f;
    int unsigned shape;
    r = rand_req(req_t'($urandom_range(3)));
    shape = $urandom_range(99);
    if (r.req_type == REQ_ASSIGN) begin
      if (shape < 10) begin
        f = $urandom_range(1023, 1);
        r.range_first = f;
        r.range_last = $urandom_range(f - 1);
      end else if (shape < 13) begin
        r.range_first = 0;
        r.range_last = 1023;
      end else begin
        f = $urandom_range(1023);
        r.range_first = f;
        r.range_last = (f + $urandom_range(15) > 1023) ? 1023 : f + $urandom_range(15);
      end
    end else if (shape < 50) begin
      r.key_hash = hash_for($urandom_range(sb.active_slots() - 1));
    end
    send_req(r);
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(99) < 70) run_migration();
      else send_noise();
    end
  endtask

  task automatic directed_reqs();
    send_req(req_of(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_LOOKUP, '1, 15, 15, 1, 255, 1023, 1023, 1));
    send_req(req_of(REQ_SET_STATUS, 5, 7, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_ASSIGN, 0, 0, 0, 0, 8'hFF, 0, 1023, 0));
    send_req(req_of(REQ_ASSIGN, 0, 0, 0, 0, 8'h12, 1023, 0, 1));
    send_req(req_of(REQ_NONE, '1, 15, 15, 1, 255, 1023, 1023, 1));
    send_req(req_of(REQ_ASSIGN, '1, 15, 15, 1, 8'hAA, 1023, 1023, 1));
    send_req(req_of(REQ_LOOKUP, 1023, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_SET_STATUS, 1023, 3, 1, 1, 0, 0, 0, 0));
    send_req(req_of(REQ_SET_STATUS, 2047, 3, 2, 1, 0, 0, 0, 0));
    send_req(req_of(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    // zero status makes the slot unassigned again
    send_req(req_of(REQ_SET_STATUS, 1023, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_LOOKUP, 1023, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_SET_STATUS, 1023, 15, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_ASSIGN, 0, 0, 0, 0, 8'h55, 0, 0, 1));
    send_req(req_of(REQ_LOOKUP, 1024, 0, 0, 0, 0, 0, 0, 0));
    send_req(req_of(REQ_SET_STATUS, 0, 15, 2, 1, 0, 0, 0, 0));
    send_req(req_of(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_key_hash = '0;
    in_status_value = '0;
    in_expected_status = '0;
    in_check_expected = 1'b0;
    in_server_id = '0;
    in_range_first = '0;
    in_range_last = '0;
    in_assign_kind = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    sender_gap_pct = 24;
    receiver_stall_pct = 51;
    configure(11'd1024, 4'd1, 4'd2, 4'd3);
    directed_reqs();
    random_phase(157);
    wait_idle();
    configure(11'd7, 4'd4, 4'd5, 4'd6);
    random_phase(100);

    wait_idle();
    sender_gap_pct = 51;
    receiver_stall_pct = 24;
    // not-moving and moved share a code: an owner fill routes to the target at once
    configure(11'd0, 4'd15, 4'd1, 4'd15);
    random_phase(60);
    wait_idle();
    configure(11'd2047, 4'd3, 4'd9, 4'd0);
    random_phase(120);

    wait_idle();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    configure(11'd1, 4'd1, 4'd2, 4'd3);
    random_phase(30);
    wait_idle();
    random_phase(30);
    wait_idle();
    configure(11'd513, 4'd1, 4'd2, 4'd3);
    hold_ticket++;
    random_phase(135);

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/srm_pkg.sv
rtl/core/slot_router_with_migration.sv
rtl/core/srm_checker.sv
verif/testbench.sv
